// ----- hdl/detector_adc_to_db_interpolator_macros.svh -----
// Assertion macros shared by the interpolator RTL.
`ifndef DETECTOR_ADC_TO_DB_INTERPOLATOR_MACROS_SVH
`define DETECTOR_ADC_TO_DB_INTERPOLATOR_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define DADB_ASSERT_IMP(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("interpolator assertion failed");

// Check that a condition implies another in the next cycle.
`define DADB_ASSERT_NXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("interpolator assertion failed");

`endif

// ----- hdl/dadb_pkg.sv -----
// Package: types, constants and microcode table of the detector dB interpolator.
package dadb_pkg;

   // Default parameter values
   localparam int ADC_BITS_DEF    = 12;
   localparam int TABLE_DEPTH_DEF = 128;

   // Field and register widths
   localparam int DATA_W    = 12;
   localparam int IDX_W     = 7;
   localparam int CFG_W     = 8;
   localparam int CSR_IDX_W = 2;
   localparam int LEVEL_W   = 16;
   localparam int LVL_W     = 17;  // level in half-dB units, up to 255 steps of 128
   localparam int QUO_W     = 11;  // interpolation quotient never exceeds 1280
   localparam int PC_W      = 4;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEN   = 2'd2;
   localparam logic [CFG_W-1:0] START_RST = 8'h1E;
   localparam logic [CFG_W-1:0] STEP_RST  = 8'hFE;
   localparam logic [CFG_W-1:0] LEN_RST   = 8'h00;

   // Command codes
   localparam logic CMD_WRITE   = 1'b0;
   localparam logic CMD_CONVERT = 1'b1;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOT_DESC = 2'd1,
      ST_EMPTY    = 2'd2
   } status_type;

   typedef struct packed {
      logic              command;
      logic [IDX_W-1:0]  entry_index;
      logic [DATA_W-1:0] entry_value;
      logic [DATA_W-1:0] sample;
   } req_payload_type;

   typedef struct packed {
      logic signed [LEVEL_W-1:0] level;
      status_type                status;
   } rsp_payload_type;

   // Sequencer control
   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_JUMP,
      SEQ_BRANCH,
      SEQ_HOLD
   } seq_type;

   typedef enum logic [3:0] {
      COND_NONE,
      COND_REQ,
      COND_WRITE,
      COND_LEN0,
      COND_ABOVE,
      COND_EXIT,
      COND_END,
      COND_BAD,
      COND_CNT0,
      COND_OUT_FREE
   } cond_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_FIRST,
      OP_SCAN,
      OP_DIFF,
      OP_MUL,
      OP_DIV_INIT,
      OP_DIV,
      OP_EMIT,
      OP_SET_WR,
      OP_SET_EMPTY,
      OP_SET_BAD,
      OP_SET_ABOVE,
      OP_SET_EXT
   } op_type;

   typedef struct packed {
      seq_type          seq;
      cond_type         cond;
      op_type           op;
      logic [PC_W-1:0]  target;
   } ucode_type;

   typedef struct packed {
      logic req_valid;
      logic is_write;
      logic len_zero;
      logic above;
      logic scan_exit;
      logic at_end;
      logic not_desc;
      logic cnt_zero;
      logic out_free;
   } flags_type;

   // Program addresses
   localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
   localparam logic [PC_W-1:0] PC_CMD   = 4'd1;
   localparam logic [PC_W-1:0] PC_EMPTY = 4'd2;
   localparam logic [PC_W-1:0] PC_FIRST = 4'd3;
   localparam logic [PC_W-1:0] PC_SCAN  = 4'd4;
   localparam logic [PC_W-1:0] PC_END   = 4'd5;
   localparam logic [PC_W-1:0] PC_BADC  = 4'd6;
   localparam logic [PC_W-1:0] PC_DIVI  = 4'd7;
   localparam logic [PC_W-1:0] PC_DIV   = 4'd8;
   localparam logic [PC_W-1:0] PC_OUT   = 4'd9;
   localparam logic [PC_W-1:0] PC_WR    = 4'd10;
   localparam logic [PC_W-1:0] PC_EMP   = 4'd11;
   localparam logic [PC_W-1:0] PC_BAD   = 4'd12;
   localparam logic [PC_W-1:0] PC_ABV   = 4'd13;
   localparam logic [PC_W-1:0] PC_EXT   = 4'd14;

   // Microprogram: one control word per step
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         PC_IDLE:  w = '{SEQ_HOLD,   COND_REQ,      OP_ACCEPT,    PC_CMD};
         PC_CMD:   w = '{SEQ_BRANCH, COND_WRITE,    OP_NOP,       PC_WR};
         PC_EMPTY: w = '{SEQ_BRANCH, COND_LEN0,     OP_NOP,       PC_EMP};
         PC_FIRST: w = '{SEQ_BRANCH, COND_ABOVE,    OP_FIRST,     PC_ABV};
         PC_SCAN:  w = '{SEQ_HOLD,   COND_EXIT,     OP_SCAN,      PC_END};
         PC_END:   w = '{SEQ_BRANCH, COND_END,      OP_DIFF,      PC_EXT};
         PC_BADC:  w = '{SEQ_BRANCH, COND_BAD,      OP_MUL,       PC_BAD};
         PC_DIVI:  w = '{SEQ_NEXT,   COND_NONE,     OP_DIV_INIT,  PC_DIV};
         PC_DIV:   w = '{SEQ_HOLD,   COND_CNT0,     OP_DIV,       PC_OUT};
         PC_OUT:   w = '{SEQ_HOLD,   COND_OUT_FREE, OP_EMIT,      PC_IDLE};
         PC_WR:    w = '{SEQ_JUMP,   COND_NONE,     OP_SET_WR,    PC_OUT};
         PC_EMP:   w = '{SEQ_JUMP,   COND_NONE,     OP_SET_EMPTY, PC_OUT};
         PC_BAD:   w = '{SEQ_JUMP,   COND_NONE,     OP_SET_BAD,   PC_OUT};
         PC_ABV:   w = '{SEQ_JUMP,   COND_NONE,     OP_SET_ABOVE, PC_OUT};
         PC_EXT:   w = '{SEQ_JUMP,   COND_NONE,     OP_SET_EXT,   PC_OUT};
         default:  w = '{SEQ_JUMP,   COND_NONE,     OP_NOP,       PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ----- hdl/dadb_if.sv -----
// Handshake channel interfaces for requests and results.
interface dadb_req_if import dadb_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface dadb_rsp_if import dadb_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/dadb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dadb_ram import dadb_pkg::*; #(
   parameter int WIDTH = DATA_W,
   parameter int DEPTH = TABLE_DEPTH_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry each cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/dadb_seq.sv -----
// Microcode sequencer: step counter, control-word table and conditional jumps.
module dadb_seq import dadb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  flags_type flags,
   output ucode_type ctrl
);

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            cond_hit;

   // Fetch the control word of the current step
   assign ctrl = ucode_rom(pc_ff);

   // Select the branch condition
   always_comb begin
      case (ctrl.cond)
         COND_REQ:      cond_hit = flags.req_valid;
         COND_WRITE:    cond_hit = flags.is_write;
         COND_LEN0:     cond_hit = flags.len_zero;
         COND_ABOVE:    cond_hit = flags.above;
         COND_EXIT:     cond_hit = flags.scan_exit;
         COND_END:      cond_hit = flags.at_end;
         COND_BAD:      cond_hit = flags.not_desc;
         COND_CNT0:     cond_hit = flags.cnt_zero;
         COND_OUT_FREE: cond_hit = flags.out_free;
         default:       cond_hit = 1'b0;
      endcase
   end

   // Advance, jump, branch or hold the step counter
   always_comb begin
      case (ctrl.seq)
         SEQ_NEXT:   pc_in = PC_W'(pc_ff + 1'b1);
         SEQ_JUMP:   pc_in = ctrl.target;
         SEQ_BRANCH: pc_in = cond_hit ? ctrl.target : PC_W'(pc_ff + 1'b1);
         SEQ_HOLD:   pc_in = cond_hit ? ctrl.target : pc_ff;
         default:    pc_in = PC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ----- hdl/dadb_dp.sv -----
// Datapath: registers, table search, interpolation divider and result register.
module dadb_dp import dadb_pkg::*; #(
   parameter int ADC_BITS    = ADC_BITS_DEF,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  ucode_type            ctrl,
   output flags_type            flags,
   dadb_req_if.sink             req_bus,
   dadb_rsp_if.source           rsp_bus
);

   localparam int SW    = (ADC_BITS < DATA_W) ? ADC_BITS : DATA_W;
   localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int PW    = SW + CFG_W;
   localparam int NW    = PW + 4;
   localparam int ACC_W = LVL_W + 5;
   localparam logic signed [ACC_W-1:0] LVL_MAX_X = ACC_W'((1 << (LEVEL_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] LVL_MIN_X = -LVL_MAX_X - ACC_W'(1);

   // Configuration registers
   logic [CFG_W-1:0] start_ff, start_in;
   logic [CFG_W-1:0] step_ff, step_in;
   logic [CFG_W-1:0] tlen_ff, tlen_in;

   // Working registers
   logic                    cmd_ff, cmd_in;
   logic [SW-1:0]           smp_ff, smp_in;
   logic [SW-1:0]           hi_ff, hi_in;
   logic [SW-1:0]           diff_ff, diff_in;
   logic [SW-1:0]           range_ff, range_in;
   logic [CFG_W-1:0]        len_ff, len_in;
   logic [CFG_W-1:0]        cnt_ff, cnt_in;
   logic signed [LVL_W-1:0] lvl_ff, lvl_in;
   logic [NW-1:0]           rem_ff, rem_in;
   logic [NW-1:0]           dvs_ff, dvs_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   status_type              stat_ff, stat_in;

   // Result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   status_type                rsp_status_ff, rsp_status_in;

   // Table memory
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [SW-1:0] wr_data;
   logic [AW-1:0] rd_addr;
   logic [SW-1:0] rd_data;

   // Helpers
   logic                    accept;
   logic                    idx_ok;
   logic                    advance;
   logic                    emit_fire;
   logic                    hit;
   logic                    div_ge;
   logic [CFG_W:0]          cnt_inc;
   logic [CFG_W-1:0]        len_clamp;
   logic [CFG_W-1:0]        abs_step;
   logic signed [LVL_W-1:0] step_ext;
   logic signed [LVL_W-1:0] start_ext;
   logic [PW-1:0]           prod;
   logic [NW-1:0]           prod10;
   logic signed [ACC_W-1:0] lvl_x;
   logic signed [ACC_W-1:0] lvl10;
   logic signed [ACC_W-1:0] quo_x;
   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] half;
   logic signed [LEVEL_W-1:0] level_sat;

   dadb_ram #(
      .WIDTH (SW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Request handshake and table writes; hold off requests during reset
   assign req_bus.ready = (ctrl.op == OP_ACCEPT) && !reset;
   assign accept        = req_bus.valid && req_bus.ready;
   assign idx_ok        = 32'(req_bus.payload.entry_index) < TABLE_DEPTH;
   assign wr_en         = accept && (req_bus.payload.command == CMD_WRITE) && idx_ok;
   assign wr_addr       = AW'(req_bus.payload.entry_index);
   assign wr_data       = req_bus.payload.entry_value[SW-1:0];

   // Derived operands
   assign step_ext  = LVL_W'($signed(step_ff));
   assign start_ext = LVL_W'($signed(start_ff));
   assign abs_step  = step_ff[CFG_W-1] ? CFG_W'(~step_ff + 1'b1) : step_ff;
   assign len_clamp = (32'(tlen_ff) > TABLE_DEPTH) ? CFG_W'(TABLE_DEPTH) : tlen_ff;
   assign cnt_inc   = {1'b0, cnt_ff} + 1'b1;
   assign prod      = PW'(diff_ff) * PW'(abs_step);
   assign prod10    = (NW'(prod) << 3) + (NW'(prod) << 1);
   assign div_ge    = rem_ff >= dvs_ff;

   // Search conditions against the entry on the read port
   assign hit = smp_ff >= rd_data;
   always_comb begin
      flags.req_valid = req_bus.valid;
      flags.is_write  = (cmd_ff == CMD_WRITE);
      flags.len_zero  = (len_ff == '0);
      flags.above     = smp_ff > rd_data;
      flags.at_end    = cnt_ff >= len_ff;
      flags.not_desc  = rd_data >= hi_ff;
      flags.scan_exit = flags.at_end || flags.not_desc || hit;
      flags.cnt_zero  = (cnt_ff == '0);
      flags.out_free  = !rsp_valid_ff || rsp_bus.ready;
   end

   // Read the next entry when stepping forward, else hold the current one
   assign advance = (ctrl.op == OP_FIRST) || ((ctrl.op == OP_SCAN) && !flags.scan_exit);
   assign rd_addr = advance ? AW'(cnt_inc) : AW'(cnt_ff);

   // Result: level*10 plus signed quotient, halved and saturated
   assign lvl_x = ACC_W'(lvl_ff);
   assign lvl10 = (lvl_x <<< 3) + (lvl_x <<< 1);
   assign quo_x = $signed(ACC_W'(quo_ff));
   assign acc   = lvl10 + (step_ff[CFG_W-1] ? -quo_x : quo_x);
   assign half  = acc >>> 1;
   always_comb begin
      if (half > LVL_MAX_X) begin
         level_sat = {1'b0, {(LEVEL_W-1){1'b1}}};
      end else if (half < LVL_MIN_X) begin
         level_sat = {1'b1, {(LEVEL_W-1){1'b0}}};
      end else begin
         level_sat = half[LEVEL_W-1:0];
      end
   end

   // Configuration writes
   always_comb begin
      start_in = start_ff;
      step_in  = step_ff;
      tlen_in  = tlen_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_START: start_in = csr_wdata;
            CSR_STEP:  step_in  = csr_wdata;
            CSR_LEN:   tlen_in  = csr_wdata;
            default:   ;
         endcase
      end
   end

   // Execute the datapath operation of the current step
   always_comb begin
      cmd_in   = cmd_ff;
      smp_in   = smp_ff;
      hi_in    = hi_ff;
      diff_in  = diff_ff;
      range_in = range_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      lvl_in   = lvl_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      quo_in   = quo_ff;
      stat_in  = stat_ff;
      case (ctrl.op)
         OP_ACCEPT: begin
            if (accept) begin
               cmd_in = req_bus.payload.command;
               smp_in = req_bus.payload.sample[SW-1:0];
               len_in = len_clamp;
               cnt_in = '0;
               lvl_in = start_ext;
            end
         end
         OP_FIRST: begin
            hi_in  = rd_data;
            cnt_in = cnt_inc[CFG_W-1:0];
         end
         OP_SCAN: begin
            if (!flags.scan_exit) begin
               hi_in  = rd_data;
               cnt_in = cnt_inc[CFG_W-1:0];
               lvl_in = lvl_ff + step_ext;
            end
         end
         OP_DIFF: begin
            diff_in  = hi_ff - smp_ff;
            range_in = hi_ff - rd_data;
         end
         OP_MUL: begin
            rem_in = prod10;
         end
         OP_DIV_INIT: begin
            cnt_in  = CFG_W'(QUO_W - 1);
            dvs_in  = NW'(range_ff) << (QUO_W - 1);
            quo_in  = '0;
            stat_in = ST_OK;
         end
         OP_DIV: begin
            rem_in = div_ge ? rem_ff - dvs_ff : rem_ff;
            quo_in = {quo_ff[QUO_W-2:0], div_ge};
            dvs_in = dvs_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
         end
         OP_SET_WR: begin
            lvl_in  = '0;
            quo_in  = '0;
            stat_in = ST_OK;
         end
         OP_SET_EMPTY: begin
            lvl_in  = '0;
            quo_in  = '0;
            stat_in = ST_EMPTY;
         end
         OP_SET_BAD: begin
            lvl_in  = '0;
            quo_in  = '0;
            stat_in = ST_NOT_DESC;
         end
         OP_SET_ABOVE: begin
            lvl_in  = lvl_ff - step_ext;
            quo_in  = '0;
            stat_in = ST_OK;
         end
         OP_SET_EXT: begin
            quo_in  = '0;
            stat_in = ST_OK;
         end
         default: ;
      endcase
   end

   // Load the result register when it is free, drop it when taken
   assign emit_fire = (ctrl.op == OP_EMIT) && flags.out_free;
   always_comb begin
      rsp_level_in  = rsp_level_ff;
      rsp_status_in = rsp_status_ff;
      if (emit_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_level_in  = level_sat;
         rsp_status_in = stat_ff;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.payload.level  = rsp_level_ff;
   assign rsp_bus.payload.status = rsp_status_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= START_RST;
         step_ff      <= STEP_RST;
         tlen_ff      <= LEN_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         step_ff      <= step_in;
         tlen_ff      <= tlen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      smp_ff        <= smp_in;
      hi_ff         <= hi_in;
      diff_ff       <= diff_in;
      range_ff      <= range_in;
      len_ff        <= len_in;
      cnt_ff        <= cnt_in;
      lvl_ff        <= lvl_in;
      rem_ff        <= rem_in;
      dvs_ff        <= dvs_in;
      quo_ff        <= quo_in;
      stat_ff       <= stat_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

// ----- hdl/detector_adc_to_db_interpolator.sv -----
// Flow: a write result goes out without a table search; an empty table, a sample above the
// first entry, a segment that is not descending and a sample below the last of len entries
// each end the search early; an interpolation scans the table one entry per cycle, then runs
// the divider on the segment that ends at the entry found.
// Throughput: one request at a time; the next is taken the cycle after its result loads.
// Reset: synchronous; restores the three registers, clears result valid, idles the sequencer.
`include "detector_adc_to_db_interpolator_macros.svh"

module detector_adc_to_db_interpolator import dadb_pkg::*; #(
   parameter int ADC_BITS    = ADC_BITS_DEF,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   dadb_req_if.sink             req_bus,
   dadb_rsp_if.source           rsp_bus
);

   ucode_type ctrl;
   flags_type flags;

   dadb_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   dadb_dp #(
      .ADC_BITS    (ADC_BITS),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ctrl      (ctrl),
      .flags     (flags),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   // Only one request in work at a time
   `DADB_ASSERT_NXT(a_one_in_flight, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready)
   // Error and empty results carry a zero level
   `DADB_ASSERT_IMP(a_err_zero, clock, reset, rsp_bus.valid && rsp_bus.payload.status != ST_OK, rsp_bus.payload.level == '0)
   // A result appears only out of the emit step
   `DADB_ASSERT_IMP(a_emit_src, clock, reset, $rose(rsp_bus.valid), $past(ctrl.op == OP_EMIT))

endmodule
